### rtl/bmaf_pkg.sv
package bmaf_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // fixed port widths
    localparam int CH_PORT_W  = 2;
    localparam int SMP_PORT_W = 12;
    localparam int WLEN_W     = 5;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_FEED,
        ST_DRAIN,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

endpackage

### rtl/block_median_adc_filter.sv
// Per-channel block median filter. The first sample of a channel after reset is reported
// directly; later samples collect in that channel's window in a sample RAM. Each item
// returns exactly one result item (channel, current value, updated flag). An item that
// does not close a window goes from acceptance through ST_PROC and ST_EMIT to the output
// register. For an item that closes a window of effective length N, the N samples are read
// from the RAM one per cycle into a row of MAX_WINDOW insertion cells, the row settles
// in ST_DRAIN, then shifts out up to the middle entries. One item is in work at a time;
// the next is accepted while a result still waits at the output. window_length 0 acts as 1,
// values above MAX_WINDOW as MAX_WINDOW.
module block_median_adc_filter import bmaf_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CH_PORT_W-1:0]  s_channel,
    input  logic [SMP_PORT_W-1:0] s_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_PORT_W-1:0]  m_result_channel,
    output logic [SMP_PORT_W-1:0] m_filtered_value,
    output logic                  m_updated,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WLEN_W-1:0]     cfg_data
);

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH     = CHANNELS * MAX_WINDOW;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W     = $clog2(MAX_WINDOW + 1);
    localparam int DRAIN_CYC = MAX_WINDOW + 2;
    localparam int DRN_W     = $clog2(DRAIN_CYC + 1);

    state_t st_reg, st_next;

    logic [WLEN_W-1:0]      wlen_reg;
    logic [CH_PORT_W-1:0]   ch_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [LEN_W-1:0]       fill_reg [CHANNELS];
    logic [CHANNELS-1:0]    primed_reg;
    logic [SAMPLE_BITS-1:0] cres_reg [CHANNELS];
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       cnt_reg;
    logic [DRN_W-1:0]       drn_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] res_reg;
    logic                   upd_reg;
    logic                   rd_v_reg;
    logic                   m_valid_reg;
    logic [CH_PORT_W-1:0]   m_chan_reg;
    logic [SMP_PORT_W-1:0]  m_val_reg;
    logic                   m_upd_reg;

    logic                   in_range;
    logic [CH_W-1:0]        ch_idx;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       cur_fill;
    logic [IDX_W-1:0]       wr_idx;
    logic [LEN_W-1:0]       new_fill;
    logic                   proc_done;
    logic [LEN_W-1:0]       half;
    logic                   even_len;
    logic [SAMPLE_BITS:0]   mid_sum;
    logic [SAMPLE_BITS-1:0] median;
    logic                   out_free;

    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    cell_ctl_t              cell_ctl;

    logic [MAX_WINDOW-1:0]  c_in_v;
    logic [MAX_WINDOW-1:0]  c_pass_v;
    logic [MAX_WINDOW-1:0]  c_hold_v;
    logic [MAX_WINDOW-1:0]  c_shin_v;
    logic [SAMPLE_BITS-1:0] c_in_d   [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] c_pass_d [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] c_hold_d [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] c_shin_d [MAX_WINDOW];

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign in_range = (32'(ch_reg) < 32'(CHANNELS));
    assign ch_idx   = CH_W'(ch_reg);

    always_comb begin
        if (wlen_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(wlen_reg) > 32'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(wlen_reg);
        end
    end

    assign cur_fill  = fill_reg[ch_idx];
    assign wr_idx    = (32'(cur_fill) >= 32'(MAX_WINDOW)) ? '0 : IDX_W'(cur_fill);
    assign new_fill  = LEN_W'(wr_idx) + LEN_W'(1);
    assign proc_done = in_range && primed_reg[ch_idx] && (new_fill >= eff_len);

    assign half     = len_reg >> 1;
    assign even_len = !len_reg[0];
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, c_hold_d[0]};
    assign median   = even_len ? mid_sum[SAMPLE_BITS:1] : c_hold_d[0];
    assign out_free = !m_valid_reg || m_ready;

    assign ram_waddr = AW'(32'(ch_idx) * 32'(MAX_WINDOW) + 32'(wr_idx));
    assign ram_raddr = AW'(32'(ch_idx) * 32'(MAX_WINDOW) + 32'(cnt_reg));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    st_next = ST_PROC;
                end
            end
            ST_PROC: begin
                st_next = proc_done ? ST_FEED : ST_EMIT;
            end
            ST_FEED: begin
                if (cnt_reg == len_reg - LEN_W'(1)) begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drn_reg == DRN_W'(DRAIN_CYC)) begin
                    st_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (cnt_reg == half) begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (st_reg == ST_IDLE);
        ram_we         = (st_reg == ST_PROC) && in_range && primed_reg[ch_idx];
        ram_re         = (st_reg == ST_FEED);
        cell_ctl.clear = (st_reg == ST_PROC);
        cell_ctl.shift = (st_reg == ST_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    assign cfg_ready = 1'b1;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= WLEN_RESET;
            primed_reg  <= '0;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            drn_reg     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c] <= '0;
                cres_reg[c] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                wlen_reg <= cfg_data;
            end
            rd_v_reg <= ram_re;

            if (st_reg == ST_PROC && in_range) begin
                if (!primed_reg[ch_idx]) begin
                    primed_reg[ch_idx] <= 1'b1;
                    cres_reg[ch_idx]   <= smp_reg;
                end else begin
                    fill_reg[ch_idx] <= proc_done ? '0 : new_fill;
                end
            end

            unique case (st_reg)
                ST_PROC:  cnt_reg <= '0;
                ST_FEED:  cnt_reg <= (st_next == ST_DRAIN) ? '0 : cnt_reg + LEN_W'(1);
                ST_SHIFT: cnt_reg <= cnt_reg + LEN_W'(1);
                default:  cnt_reg <= cnt_reg;
            endcase

            if (st_reg == ST_DRAIN) begin
                drn_reg <= drn_reg + DRN_W'(1);
            end else begin
                drn_reg <= '0;
            end

            if (st_reg == ST_SHIFT && cnt_reg == half) begin
                cres_reg[ch_idx] <= median;
            end

            if (st_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_channel;
            smp_reg <= SAMPLE_BITS'(s_sample);
        end
        if (st_reg == ST_PROC) begin
            len_reg <= eff_len;
            if (!in_range) begin
                res_reg <= '0;
                upd_reg <= 1'b0;
            end else if (!primed_reg[ch_idx]) begin
                res_reg <= smp_reg;
                upd_reg <= 1'b1;
            end else begin
                res_reg <= cres_reg[ch_idx];
                upd_reg <= proc_done;
            end
        end
        if (st_reg == ST_SHIFT) begin
            if (even_len && (cnt_reg == half - LEN_W'(1))) begin
                lo_reg <= c_hold_d[0];
            end
            if (cnt_reg == half) begin
                res_reg <= median;
            end
        end
        if (st_reg == ST_EMIT && out_free) begin
            m_chan_reg <= ch_reg;
            m_val_reg  <= SMP_PORT_W'(res_reg);
            m_upd_reg  <= upd_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_channel = m_chan_reg;
    assign m_filtered_value = m_val_reg;
    assign m_updated        = m_upd_reg;

    // ------------------------------------------------------------------
    // sample store and sorting row
    // ------------------------------------------------------------------
    bmaf_ram #(
        .W     (SAMPLE_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (smp_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign c_in_v[i] = rd_v_reg;
            assign c_in_d[i] = ram_rdata;
        end else begin : g_next
            assign c_in_v[i] = c_pass_v[i-1];
            assign c_in_d[i] = c_pass_d[i-1];
        end
        if (i == MAX_WINDOW - 1) begin : g_last
            assign c_shin_v[i] = 1'b0;
            assign c_shin_d[i] = '0;
        end else begin : g_mid
            assign c_shin_v[i] = c_hold_v[i+1];
            assign c_shin_d[i] = c_hold_d[i+1];
        end

        bmaf_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cell_ctl),
            .in_v    (c_in_v[i]),
            .in_d    (c_in_d[i]),
            .shin_v  (c_shin_v[i]),
            .shin_d  (c_shin_d[i]),
            .pass_v  (c_pass_v[i]),
            .pass_d  (c_pass_d[i]),
            .hold_v  (c_hold_v[i]),
            .hold_d  (c_hold_d[i])
        );
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a completed window restarts empty
    a_fill_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_PROC && proc_done) |=> (fill_reg[ch_idx] == '0))
        else $error("window did not restart after completion");

    // the row holds exactly the window once it has settled
    a_row_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SHIFT && $past(st_reg) == ST_DRAIN)
            |-> ($countones(c_hold_v) == 32'(len_reg)))
        else $error("sorting row does not hold the whole window");

    // values leave the row in ascending order
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SHIFT && $past(st_reg) == ST_SHIFT && c_hold_v[0]
            && $past(c_hold_v[0])) |-> ($past(c_hold_d[0]) <= c_hold_d[0]))
        else $error("sorting row output out of order");

    // the last cell never has to pass a value on
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !c_pass_v[MAX_WINDOW-1])
        else $error("sorting row overflow");

endmodule

### rtl/bmaf_ram.sv
module bmaf_ram import bmaf_pkg::*; #(
    parameter int W     = SAMPLE_BITS_DEF,
    parameter int DEPTH = CHANNELS_DEF * MAX_WINDOW_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bmaf_cell.sv
module bmaf_cell import bmaf_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cell_ctl_t    ctl,
    input  logic         in_v,
    input  logic [W-1:0] in_d,
    input  logic         shin_v,
    input  logic [W-1:0] shin_d,
    output logic         pass_v,
    output logic [W-1:0] pass_d,
    output logic         hold_v,
    output logic [W-1:0] hold_d
);

    logic         hold_v_reg;
    logic [W-1:0] hold_d_reg;
    logic         pass_v_reg;
    logic [W-1:0] pass_d_reg;
    logic         take_in;

    // keep the smaller of held and incoming value, hand the larger on
    assign take_in = in_v && (!hold_v_reg || (in_d < hold_d_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            hold_v_reg <= 1'b0;
            pass_v_reg <= 1'b0;
        end else if (ctl.shift) begin
            hold_v_reg <= shin_v;
            pass_v_reg <= 1'b0;
        end else begin
            pass_v_reg <= in_v && hold_v_reg;
            if (in_v) begin
                hold_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            hold_d_reg <= shin_d;
        end else if (take_in) begin
            hold_d_reg <= in_d;
        end
        pass_d_reg <= take_in ? hold_d_reg : in_d;
    end

    assign pass_v = pass_v_reg;
    assign pass_d = pass_d_reg;
    assign hold_v = hold_v_reg;
    assign hold_d = hold_d_reg;

endmodule
